/* design/i2d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared constants and types for the decimal ASCII formatter.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned CNT_W      = $clog2(WORD_W);
  localparam int unsigned POS_W      = $clog2(NUM_DIGITS);
  localparam int unsigned LEN_W      = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_LEN  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

/* design/int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Formats a 32-bit word as decimal ASCII text, one character per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): cmd selects unsigned (0) or signed (1)
// reading of value. Output channel (out_valid/out_ready): one item per
// character, most significant first, with a leading '-' for signed negatives.
// last marks the final character; length is the full text length on every
// item. Zero prints as a single '0', no zero padding.
// Timing: after an item is accepted the shared shift-and-add-3 unit takes one
// input bit per cycle, a separate state then finds the digit count, then the
// characters leave at one per cycle while the receiver is ready. The
// bit-serial conversion takes up most of the time per item.
// in_ready is high only while the block is idle; the next item may be taken
// while the final character still waits in the output register.
// Reset (rst, synchronous) empties the output register and returns to idle.
// When the receiver stalls, the current character holds and emission pauses.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  character,
  output logic        last,
  output logic [3:0]  length
);

  i2d_pkg::state_t state, state_next;

  logic [i2d_pkg::WORD_W-1:0] mag;
  logic [i2d_pkg::BCD_W-1:0]  bcd;
  logic [i2d_pkg::BCD_W-1:0]  bcd_next;
  logic [i2d_pkg::CNT_W-1:0]  cnt;
  logic [i2d_pkg::POS_W-1:0]  pos;
  logic                       neg;
  logic                       sign_pend;
  logic [i2d_pkg::LEN_W-1:0]  total;
  logic [i2d_pkg::LEN_W-1:0]  ndig;
  logic                       load;
  logic [3:0]                 nib;

  i2d_dabble u_dabble (
    .bcd      (bcd),
    .bit_in   (mag[i2d_pkg::WORD_W-1]),
    .bcd_next (bcd_next)
  );

  assign in_ready = (state == i2d_pkg::ST_IDLE);
  assign load     = (state == i2d_pkg::ST_EMIT) && (out_ready || !out_valid);
  assign nib      = bcd[4*pos +: 4];

  // count significant digits: highest nonzero digit, at least one
  always_comb begin
    ndig = i2d_pkg::LEN_W'(1);
    for (int i = 0; i < int'(i2d_pkg::NUM_DIGITS); i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        ndig = i2d_pkg::LEN_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      i2d_pkg::ST_IDLE: begin
        if (in_valid) state_next = i2d_pkg::ST_CONV;
      end
      i2d_pkg::ST_CONV: begin
        if (cnt == i2d_pkg::CNT_W'(i2d_pkg::WORD_W - 1)) state_next = i2d_pkg::ST_LEN;
      end
      i2d_pkg::ST_LEN: begin
        state_next = i2d_pkg::ST_EMIT;
      end
      i2d_pkg::ST_EMIT: begin
        if (load && !sign_pend && (pos == '0)) state_next = i2d_pkg::ST_IDLE;
      end
      default: state_next = i2d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= i2d_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      i2d_pkg::ST_IDLE: begin
        if (in_valid) begin
          neg <= cmd & value[31];
          mag <= (cmd & value[31]) ? (~value + 32'd1) : value;
          bcd <= '0;
          cnt <= '0;
        end
      end
      i2d_pkg::ST_CONV: begin
        bcd <= bcd_next;
        mag <= {mag[i2d_pkg::WORD_W-2:0], 1'b0};
        cnt <= cnt + i2d_pkg::CNT_W'(1);
      end
      i2d_pkg::ST_LEN: begin
        total     <= ndig + i2d_pkg::LEN_W'(neg);
        pos       <= i2d_pkg::POS_W'(ndig - i2d_pkg::LEN_W'(1));
        sign_pend <= neg;
      end
      i2d_pkg::ST_EMIT: begin
        if (load) begin
          length <= total;
          if (sign_pend) begin
            character <= i2d_pkg::CHAR_MINUS;
            last      <= 1'b0;
            sign_pend <= 1'b0;
          end else begin
            character <= i2d_pkg::CHAR_ZERO + {4'd0, nib};
            last      <= (pos == '0);
            if (pos != '0) pos <= pos - i2d_pkg::POS_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/i2d_dabble.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_dabble
// One shift-and-add-3 step of binary to BCD conversion.
// ----------------------------------------------------------------------------
module i2d_dabble (
  input  logic [i2d_pkg::BCD_W-1:0] bcd,
  input  logic                      bit_in,
  output logic [i2d_pkg::BCD_W-1:0] bcd_next
);

  logic [i2d_pkg::BCD_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < int'(i2d_pkg::NUM_DIGITS); i++) begin
      // digit of 5 or more doubles past 9: pre-correct by 3
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign bcd_next = {adj[i2d_pkg::BCD_W-2:0], bit_in};

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the decimal ASCII formatter.
// ----------------------------------------------------------------------------
// Offers words in both modes. First come hand-picked edge values, then random
// words biased toward digit-count boundaries and sign extremes. Each accepted
// word is expanded into its expected characters. Those are either typed out
// in the table or worked out by a local decimal formatter. Every character the
// block emits is compared with the oldest pending one. Both sides idle and
// stall at random. One long receiver hold-off backs the block up, and one
// sender pause lets the output drain completely.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_SIGNED   = 1'b1;

  localparam int NUM_RANDOM   = 288;
  localparam int PAUSE_ITEM   = 120;   // sender waits for a full drain here
  localparam int HOLD_AT_CHAR = 400;   // receiver starts its long hold-off here
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [3:0] len;
  } char_result_t;

  typedef struct {
    logic        mode;
    logic [31:0] word;
    string       text;   // empty: use the formatter
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  character;
  logic        last;
  logic [3:0]  length;

  char_result_t pending_chars[$];
  int           error_count = 0;
  int           items_sent = 0;
  int           chars_seen = 0;
  int           cycle_count = 0;

  stim_row_t edge_rows[] = '{
    '{MODE_UNSIGNED, 32'h0000_0000, "0"},
    '{MODE_SIGNED,   32'h0000_0000, "0"},
    '{MODE_UNSIGNED, 32'hFFFF_FFFF, "4294967295"},
    '{MODE_SIGNED,   32'hFFFF_FFFF, "-1"},
    '{MODE_SIGNED,   32'h8000_0000, "-2147483648"},
    '{MODE_UNSIGNED, 32'h8000_0000, "2147483648"},
    '{MODE_SIGNED,   32'h7FFF_FFFF, "2147483647"},
    '{MODE_UNSIGNED, 32'h7FFF_FFFF, "2147483647"},
    '{MODE_UNSIGNED, 32'd9,         "9"},
    '{MODE_UNSIGNED, 32'd10,        "10"},
    '{MODE_SIGNED,   32'd1,         "1"},
    '{MODE_SIGNED,   32'hFFFF_FFF6, "-10"},
    '{MODE_UNSIGNED, 32'd999999999, "999999999"},
    '{MODE_UNSIGNED, 32'h3B9A_CA00, "1000000000"},
    '{MODE_SIGNED,   32'h3B9A_CA00, "1000000000"},
    '{MODE_SIGNED,   32'hC465_3600, "-1000000000"},
    '{MODE_UNSIGNED, 32'd12345,     ""},
    '{MODE_SIGNED,   32'hDEAD_BEEF, ""},
    '{MODE_UNSIGNED, 32'hDEAD_BEEF, ""},
    '{MODE_UNSIGNED, 32'hAAAA_AAAA, ""},
    '{MODE_SIGNED,   32'h5555_5555, ""},
    '{MODE_SIGNED,   32'h8000_0001, ""}
  };

  int_to_decimal_ascii DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last),
    .length    (length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Expand a word into its characters, most significant first.
  function automatic void predict_decimal(input logic mode, input logic [31:0] word);
    logic        neg;
    logic [31:0] mag;
    logic [7:0]  digit_buf [0:9];
    int          ndig;
    int          total;
    logic [7:0]  ch;

    neg  = (mode == MODE_SIGNED) && word[31];
    mag  = neg ? (~word + 32'd1) : word;
    ndig = 0;
    do begin
      digit_buf[ndig] = i2d_pkg::CHAR_ZERO + 8'(mag % 32'd10);
      mag  = mag / 32'd10;
      ndig++;
    end while (mag != 0);
    total = ndig + (neg ? 1 : 0);
    for (int k = 0; k < total; k++) begin
      ch = (neg && k == 0) ? i2d_pkg::CHAR_MINUS : digit_buf[total - 1 - k];
      pending_chars.push_back('{ch, k == total - 1, 4'(total)});
    end
  endfunction

  function automatic void queue_text(input string s);
    for (int k = 0; k < s.len(); k++)
      pending_chars.push_back('{8'(s[k]), k == s.len() - 1, 4'(s.len())});
  endfunction

  function automatic int pick_gap();
    int r;

    if (items_sent >= 60 && items_sent < 100)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pow10(input int n);
    logic [31:0] p;

    p = 32'd1;
    for (int k = 0; k < n; k++)
      p = p * 32'd10;
    return p;
  endfunction

  task automatic offer_word(input logic mode, input logic [31:0] word, input string text);
    int gap;

    gap = pick_gap();
    if (items_sent == PAUSE_ITEM) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_chars.size() != 0)
        @(posedge clk);
    end else if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= mode;
    value    <= word;
    do @(posedge clk); while (!in_ready);
    if (text.len() != 0)
      queue_text(text);
    else
      predict_decimal(mode, word);
    items_sent++;
  endtask

  // Sender
  initial begin
    logic        mode;
    logic [31:0] word;
    int          sel;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (edge_rows[i])
      offer_word(edge_rows[i].mode, edge_rows[i].word, edge_rows[i].text);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      mode = 1'($urandom);
      sel  = $urandom_range(0, 9);
      case (sel)
        0, 1, 2: word = $urandom;
        3: word = $urandom_range(0, 20);
        4: word = pow10($urandom_range(1, 9)) + $urandom_range(0, 2) - 32'd1;
        5: begin
          mode = MODE_SIGNED;
          word = -32'($urandom_range(1, 20));
        end
        6: begin
          case ($urandom_range(0, 2))
            0: word = 32'h8000_0000 + $urandom_range(0, 5);
            1: word = 32'h7FFF_FFFF - $urandom_range(0, 5);
            default: word = 32'hFFFF_FFFF - $urandom_range(0, 5);
          endcase
        end
        default: word = $urandom >> $urandom_range(0, 31);
      endcase
      offer_word(mode, word, "");
    end

    in_valid <= 1'b0;
    while (pending_chars.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // Receiver: check, then decide readiness for the next edge
  initial begin
    char_result_t want;
    int           stall_left;
    int           r;
    bit           held_off;

    stall_left = 0;
    held_off   = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected character 0x%02h", character);
          error_count++;
        end else begin
          want = pending_chars.pop_front();
          if (character !== want.ch) begin
            $error("character: expected 0x%02h, got 0x%02h", want.ch, character);
            error_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            error_count++;
          end
          if (length !== want.len) begin
            $error("length: expected %0d, got %0d", want.len, length);
            error_count++;
          end
        end
        chars_seen++;
      end

      if (!held_off && chars_seen >= HOLD_AT_CHAR) begin
        held_off   = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (chars_seen >= 100 && chars_seen < 200) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready <= 1'b1;
        end else begin
          out_ready  <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(15, 40);
        end
      end
    end
  end

endmodule

/* int_to_decimal_ascii.f */
design/i2d_pkg.sv
design/i2d_dabble.sv
design/int_to_decimal_ascii.sv
sim/testbench.sv
